// ===== rtl/two_finger_rotation_detector_top_macros.svh =====
// Assertion macros for the two-finger rotation detector.
`ifndef TWO_FINGER_ROTATION_DETECTOR_TOP_MACROS_SVH
`define TWO_FINGER_ROTATION_DETECTOR_TOP_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define TFR_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define TFR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/tfr_pkg.sv =====
// Shared constants and the arctangent table of the rotation detector.
package tfr_pkg;

    localparam int COORD_BITS  = 16;
    localparam int DIFF_W      = COORD_BITS + 1;
    localparam int ANGLE_W     = 16;
    localparam int THRESH_W    = 15;
    localparam int TOTAL_W     = 32;
    localparam int PRESCALE_SH = 24;
    localparam int CORDIC_XW   = 44;
    localparam int CORDIC_ZW   = 26;
    localparam int ATAN_W      = 21;
    localparam int STEP_IDX_W  = 5;

    localparam logic [1:0] CMD_DOWN   = 2'd0;
    localparam logic [1:0] CMD_MOTION = 2'd1;
    localparam logic [1:0] CMD_UP     = 2'd2;
    localparam logic [1:0] CMD_OTHER  = 2'd3;

    localparam logic [1:0] ACT_UNKNOWN = 2'd0;
    localparam logic [1:0] ACT_BEGIN   = 2'd1;
    localparam logic [1:0] ACT_UPDATE  = 2'd2;
    localparam logic [1:0] ACT_END     = 2'd3;

    localparam logic [THRESH_W-1:0] THRESH_RESET = 15'd640;

    localparam logic signed [DIFF_W-1:0] HALF_TURN = 17'sd23040;
    localparam logic signed [DIFF_W-1:0] FULL_TURN = 17'sd46080;
    localparam logic signed [CORDIC_ZW-1:0] HALF_TURN_Z = 26'sd5898240;

    function automatic logic [ATAN_W-1:0] atan_step(input logic [STEP_IDX_W-1:0] idx);
        logic [ATAN_W-1:0] v;
        case (idx)
            5'd0:  v = 21'd1474560;
            5'd1:  v = 21'd870484;
            5'd2:  v = 21'd460940;
            5'd3:  v = 21'd233473;
            5'd4:  v = 21'd117189;
            5'd5:  v = 21'd58652;
            5'd6:  v = 21'd29333;
            5'd7:  v = 21'd14667;
            5'd8:  v = 21'd7334;
            5'd9:  v = 21'd3667;
            5'd10: v = 21'd1833;
            5'd11: v = 21'd917;
            5'd12: v = 21'd458;
            5'd13: v = 21'd229;
            5'd14: v = 21'd115;
            5'd15: v = 21'd57;
            5'd16: v = 21'd29;
            5'd17: v = 21'd14;
            5'd18: v = 21'd7;
            5'd19: v = 21'd4;
            5'd20: v = 21'd2;
            5'd21: v = 21'd1;
            default: v = 21'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/tfr_in_if.sv =====
// Touch event channel.
interface tfr_in_if;
    logic                valid;
    logic                ready;
    logic [1:0]          cmd;
    logic [3:0]          slot;
    logic signed [15:0]  pos_x;
    logic signed [15:0]  pos_y;

    modport source (output valid, cmd, slot, pos_x, pos_y, input ready);
    modport sink   (input valid, cmd, slot, pos_x, pos_y, output ready);
endinterface

// ===== rtl/tfr_out_if.sv =====
// Gesture result channel.
interface tfr_out_if;
    logic                valid;
    logic                ready;
    logic [1:0]          action;
    logic signed [31:0]  total_angle;
    logic                rotating;

    modport source (output valid, action, total_angle, rotating, input ready);
    modport sink   (input valid, action, total_angle, rotating, output ready);
endinterface

// ===== rtl/tfr_cfg_if.sv =====
// Threshold register write channel.
interface tfr_cfg_if;
    logic        valid;
    logic        ready;
    logic [14:0] start_threshold;

    modport source (output valid, start_threshold, input ready);
    modport sink   (input valid, start_threshold, output ready);
endinterface

// ===== rtl/tfr_cordic.sv =====
// Iterative vectoring CORDIC atan2, one micro-rotation per cycle.
module tfr_cordic #(
    parameter int STEPS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic signed [tfr_pkg::DIFF_W-1:0]    i_dx,
    input  logic signed [tfr_pkg::DIFF_W-1:0]    i_dy,
    output logic                                 o_done,
    output logic signed [tfr_pkg::ANGLE_W-1:0]   o_angle
);
    localparam int XW    = tfr_pkg::CORDIC_XW;
    localparam int ZW    = tfr_pkg::CORDIC_ZW;
    localparam int CNT_W = $clog2(STEPS + 1);

    typedef enum logic [1:0] {C_IDLE, C_RUN, C_ROUND} t_cstate;

    t_cstate                 r_state;
    logic [CNT_W-1:0]        r_cnt;
    logic signed [XW-1:0]    r_x, r_y;
    logic signed [ZW-1:0]    r_z;
    logic                    r_done;
    logic signed [tfr_pkg::ANGLE_W-1:0] r_angle;

    logic signed [XW-1:0]    xs, ys, lx, ly;
    logic signed [ZW-1:0]    a, zr;
    logic signed [17:0]      rz;

    always_comb begin
        xs = r_x >>> r_cnt;
        ys = r_y >>> r_cnt;
        a  = $signed(ZW'(tfr_pkg::atan_step(tfr_pkg::STEP_IDX_W'(r_cnt))));
        lx = {{(XW-tfr_pkg::DIFF_W-tfr_pkg::PRESCALE_SH){i_dx[tfr_pkg::DIFF_W-1]}}, i_dx,
              {tfr_pkg::PRESCALE_SH{1'b0}}};
        ly = {{(XW-tfr_pkg::DIFF_W-tfr_pkg::PRESCALE_SH){i_dy[tfr_pkg::DIFF_W-1]}}, i_dy,
              {tfr_pkg::PRESCALE_SH{1'b0}}};
        zr = (r_z + ZW'(128)) >>> 8;
        rz = zr[17:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                C_IDLE: begin
                    if (i_start) begin
                        r_state <= C_RUN;
                        if (i_dx == '0 && i_dy == '0) begin
                            r_z   <= '0;
                            r_cnt <= CNT_W'(STEPS);
                        end else begin
                            r_cnt <= '0;
                            if (i_dx[tfr_pkg::DIFF_W-1]) begin
                                r_x <= -lx;
                                r_y <= -ly;
                                r_z <= i_dy[tfr_pkg::DIFF_W-1] ? -tfr_pkg::HALF_TURN_Z
                                                               : tfr_pkg::HALF_TURN_Z;
                            end else begin
                                r_x <= lx;
                                r_y <= ly;
                                r_z <= '0;
                            end
                        end
                    end
                end
                C_RUN: begin
                    if (r_cnt == CNT_W'(STEPS)) begin
                        r_state <= C_ROUND;
                    end else begin
                        if (r_y[XW-1]) begin
                            r_x <= r_x - ys;
                            r_y <= r_y + xs;
                            r_z <= r_z - a;
                        end else if (r_y != '0) begin
                            r_x <= r_x + ys;
                            r_y <= r_y - xs;
                            r_z <= r_z + a;
                        end
                        r_cnt <= r_cnt + CNT_W'(1);
                    end
                end
                C_ROUND: begin
                    if (rz > 18'sd23040) begin
                        r_angle <= 16'sd23040;
                    end else if (rz < -18'sd23040) begin
                        r_angle <= -16'sd23040;
                    end else begin
                        r_angle <= rz[15:0];
                    end
                    r_done  <= 1'b1;
                    r_state <= C_IDLE;
                end
                default: r_state <= C_IDLE;
            endcase
        end
    end

    assign o_done  = r_done;
    assign o_angle = r_angle;
endmodule

// ===== rtl/two_finger_rotation_detector_top.sv =====
// Top level of the two-finger rotation detector.
//
// i_evt carries touch events (down, motion, up) with slot and coordinates.
// o_res returns one beat per event: action code, running total angle in
// 1/128 degree and the rotating flag, both taken after the event.
// i_cfg writes the start threshold; it is always ready. The user must write it
// only while the block is idle; the block itself does not enforce this.
// Events that need no angle go from idle through S_DONE to the output register.
// Events that measure the finger angle (second finger down, motion while
// ready) first wait in S_ANGLE for the iterative CORDIC, which runs one
// micro-rotation per cycle; S_DONE waits while the output register holds an
// untaken result.
// One event is in work at a time; i_evt.ready is high only when the block is
// idle.
// The result sits in an output register; a new event is accepted while it
// waits, and the next result holds until the receiver takes the previous one.
// Reset clears the gesture state and sets the threshold to 640 (5 degrees).
`include "two_finger_rotation_detector_top_macros.svh"
module two_finger_rotation_detector_top #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tfr_in_if.sink      i_evt,
    tfr_out_if.source   o_res,
    tfr_cfg_if.sink     i_cfg
);
    localparam int AW = tfr_pkg::ANGLE_W;
    localparam int DW = tfr_pkg::DIFF_W;

    typedef enum logic [1:0] {S_IDLE, S_ANGLE, S_DONE} t_state;

    t_state                r_state, n_state;
    logic signed [15:0]    r_dx [2], n_dx [2];
    logic signed [15:0]    r_dy [2], n_dy [2];
    logic signed [15:0]    r_cx [2], n_cx [2];
    logic signed [15:0]    r_cy [2], n_cy [2];
    logic                  r_pres [2], n_pres [2];
    logic signed [4:0]     r_fc, n_fc;
    logic                  r_ready, n_ready;
    logic                  r_rot, n_rot;
    logic signed [AW-1:0]  r_start, n_start;
    logic signed [AW-1:0]  r_prev, n_prev;
    logic signed [31:0]    r_acc, n_acc;
    logic [1:0]            r_act, n_act;
    logic                  r_motion, n_motion;
    logic [tfr_pkg::THRESH_W-1:0] r_thr;
    logic                  r_out_valid, n_out_valid;
    logic [1:0]            r_out_act, n_out_act;
    logic signed [31:0]    r_out_total, n_out_total;
    logic                  r_out_rot, n_out_rot;

    logic                  evt_acc, clr, ang_start, ang_done;
    logic signed [DW-1:0]  ang_dx, ang_dy, diff, absd, inc, inc_w;
    logic signed [AW-1:0]  ang;
    logic signed [32:0]    sum;

    tfr_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (ang_start),
        .i_dx    (ang_dx),
        .i_dy    (ang_dy),
        .o_done  (ang_done),
        .o_angle (ang)
    );

    assign evt_acc     = i_evt.valid && i_evt.ready;
    assign i_evt.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;

    always_comb begin
        n_state = r_state;
        n_dx = r_dx; n_dy = r_dy; n_cx = r_cx; n_cy = r_cy; n_pres = r_pres;
        n_fc = r_fc; n_ready = r_ready; n_rot = r_rot;
        n_start = r_start; n_prev = r_prev; n_acc = r_acc;
        n_act = r_act; n_motion = r_motion;
        n_out_valid = r_out_valid && !o_res.ready;
        n_out_act = r_out_act; n_out_total = r_out_total; n_out_rot = r_out_rot;
        clr = 1'b0;
        ang_start = 1'b0;
        diff = {ang[AW-1], ang} - {r_start[AW-1], r_start};
        absd = diff[DW-1] ? -diff : diff;
        inc  = {ang[AW-1], ang} - {r_prev[AW-1], r_prev};
        if (inc >= tfr_pkg::HALF_TURN) begin
            inc_w = inc - tfr_pkg::FULL_TURN;
        end else if (inc <= -tfr_pkg::HALF_TURN) begin
            inc_w = inc + tfr_pkg::FULL_TURN;
        end else begin
            inc_w = inc;
        end
        sum = {r_acc[31], r_acc} + 33'(inc_w);
        case (r_state)
            S_IDLE: begin
                if (evt_acc) begin
                    n_act   = tfr_pkg::ACT_UNKNOWN;
                    n_state = S_DONE;
                    case (i_evt.cmd)
                        tfr_pkg::CMD_DOWN: begin
                            if (r_fc < 5'sd15) n_fc = r_fc + 5'sd1;
                            if (i_evt.slot > 4'd1) begin
                                if (r_rot) begin
                                    n_act = tfr_pkg::ACT_END;
                                end else if (r_ready) begin
                                    clr = 1'b1;
                                end
                            end else begin
                                n_dx[i_evt.slot[0]]   = i_evt.pos_x;
                                n_dy[i_evt.slot[0]]   = i_evt.pos_y;
                                n_pres[i_evt.slot[0]] = 1'b1;
                                if (n_pres[0] && n_pres[1]) begin
                                    n_ready   = 1'b1;
                                    n_cx      = n_dx;
                                    n_cy      = n_dy;
                                    ang_start = 1'b1;
                                    n_motion  = 1'b0;
                                    n_state   = S_ANGLE;
                                end
                            end
                        end
                        tfr_pkg::CMD_MOTION: begin
                            if (r_ready) begin
                                if (r_fc < 5'sd0 || r_fc > 5'sd1) begin
                                    if (!r_rot) clr = 1'b1;
                                end else begin
                                    if (i_evt.slot <= 4'd1) begin
                                        n_cx[i_evt.slot[0]] = i_evt.pos_x;
                                        n_cy[i_evt.slot[0]] = i_evt.pos_y;
                                    end
                                    ang_start = 1'b1;
                                    n_motion  = 1'b1;
                                    n_state   = S_ANGLE;
                                end
                            end
                        end
                        tfr_pkg::CMD_UP: begin
                            if (r_rot) begin
                                n_ready = 1'b0;
                                n_rot   = 1'b0;
                                if (i_evt.slot <= 4'd1) n_pres[i_evt.slot[0]] = 1'b0;
                                n_act = tfr_pkg::ACT_END;
                            end else begin
                                clr = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                    if (clr) begin
                        n_dx = '{default: '0}; n_dy = '{default: '0};
                        n_cx = '{default: '0}; n_cy = '{default: '0};
                        n_pres = '{default: 1'b0};
                        n_fc = -5'sd1; n_ready = 1'b0; n_rot = 1'b0;
                        n_start = '0; n_prev = '0; n_acc = '0;
                    end
                end
            end
            S_ANGLE: begin
                if (ang_done) begin
                    n_state = S_DONE;
                    if (!r_motion) begin
                        n_start = ang;
                    end else if (!r_rot) begin
                        if ($unsigned(absd) >= {2'b00, r_thr}) begin
                            n_start = ang;
                            n_prev  = ang;
                            n_rot   = 1'b1;
                            n_act   = tfr_pkg::ACT_BEGIN;
                        end
                    end else begin
                        if (sum[32] != sum[31]) begin
                            n_acc = sum[32] ? 32'sh80000000 : 32'sh7FFFFFFF;
                        end else begin
                            n_acc = sum[31:0];
                        end
                        n_prev = ang;
                        n_act  = tfr_pkg::ACT_UPDATE;
                    end
                end
            end
            S_DONE: begin
                if (!r_out_valid || o_res.ready) begin
                    n_out_valid = 1'b1;
                    n_out_act   = r_act;
                    n_out_total = r_acc;
                    n_out_rot   = r_rot;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        ang_dx = {n_cx[0][15], n_cx[0]} - {n_cx[1][15], n_cx[1]};
        ang_dy = {n_cy[0][15], n_cy[0]} - {n_cy[1][15], n_cy[1]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_dx        <= '{default: '0};
            r_dy        <= '{default: '0};
            r_cx        <= '{default: '0};
            r_cy        <= '{default: '0};
            r_pres      <= '{default: 1'b0};
            r_fc        <= -5'sd1;
            r_ready     <= 1'b0;
            r_rot       <= 1'b0;
            r_start     <= '0;
            r_prev      <= '0;
            r_acc       <= '0;
            r_motion    <= 1'b0;
            r_thr       <= tfr_pkg::THRESH_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_dx        <= n_dx;
            r_dy        <= n_dy;
            r_cx        <= n_cx;
            r_cy        <= n_cy;
            r_pres      <= n_pres;
            r_fc        <= n_fc;
            r_ready     <= n_ready;
            r_rot       <= n_rot;
            r_start     <= n_start;
            r_prev      <= n_prev;
            r_acc       <= n_acc;
            r_act       <= n_act;
            r_motion    <= n_motion;
            r_out_valid <= n_out_valid;
            r_out_act   <= n_out_act;
            r_out_total <= n_out_total;
            r_out_rot   <= n_out_rot;
            if (i_cfg.valid && i_cfg.ready) r_thr <= i_cfg.start_threshold;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.action      = r_out_act;
    assign o_res.total_angle = r_out_total;
    assign o_res.rotating    = r_out_rot;

    `TFR_ASSERT_SAME(a_rot_needs_ready, i_clk, i_rst_n, r_rot, r_ready, "rotating without ready")
    `TFR_ASSERT_NEXT(a_one_in_work, i_clk, i_rst_n, evt_acc, !i_evt.ready, "event taken while busy")
    `TFR_ASSERT_SAME(a_fc_range, i_clk, i_rst_n, 1'b1, r_fc >= -5'sd1, "finger count out of range")
endmodule
